[rtl/tgarle_pkg.sv]
// tgarle_pkg: shared constants and types for the tga run-length pixel decoder
// no dependencies; imported by tga_rle_pixel_decoder_unit
`timescale 1ns / 1ps
`default_nettype none

package tgarle_pkg;

   // configuration register indexes
   localparam logic [1:0] CSR_BYTES_PER_PIXEL = 2'd0;
   localparam logic [1:0] CSR_RLE_ENABLE      = 2'd1;
   localparam logic [1:0] CSR_PIXEL_TOTAL     = 2'd2;

   localparam int unsigned CSR_INDEX_BITS = 2;
   localparam int unsigned CSR_DATA_BITS  = 32;

   // register reset values
   localparam logic [2:0] BPP_RESET = 3'd4;
   localparam logic       RLE_RESET = 1'b1;

   // pixel sizes
   localparam logic [2:0] BPP_RGB  = 3'd3;
   localparam logic [1:0] LAST_RGB  = 2'd2;
   localparam logic [1:0] LAST_RGBA = 2'd3;

   localparam int unsigned RUN_FLAG_BIT = 7;

   localparam int unsigned RSP_DATA_BITS = 40;

   typedef struct packed {
      logic [7:0] repeat_count;
      logic [7:0] alpha;
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
      logic       image_end;
   } pixel_type;

endpackage

`default_nettype wire

[rtl/tga_rle_pixel_decoder_unit.sv]
// tga_rle_pixel_decoder_unit: byte-stream decoder for tga true-colour image data
// depends on tgarle_pkg; output register plus skid stage on the result side
// completed pixels go to the output register, or to the skid stage while it is held
// throughput: one byte per cycle; req_tready only drops when both result stages hold
//   a transfer, the decode is a single subtract/compare and add on the pixel counter
// reset (synchronous, active high) clears packet state, pixel counter and both
//   result stages; registers return to 4 bytes per pixel, run-length on, total of 1
`timescale 1ns / 1ps
`default_nettype none

module tga_rle_pixel_decoder_unit
   import tgarle_pkg::*;
#(
   parameter int unsigned COUNT_BITS = 32
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_tvalid,
   output logic                           req_tready,
   input  wire logic [7:0]                req_tdata,   // [7:0] stream_byte
   output logic                           rsp_tvalid,
   input  wire logic                      rsp_tready,
   output logic [RSP_DATA_BITS-1:0]       rsp_tdata,   // red, green, blue, alpha, repeat_count
   output logic                           rsp_tlast,   // image_end
   input  wire logic                      csr_we,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   localparam int unsigned WIDE_BITS = (COUNT_BITS > CSR_DATA_BITS) ? COUNT_BITS : CSR_DATA_BITS;

   // configuration
   logic [2:0]            bpp_ff;
   logic                  rle_ff;
   logic [COUNT_BITS-1:0] limit_ff;
   logic [COUNT_BITS-1:0] limit_in;

   // decode state
   logic                  expect_header_ff, expect_header_in;
   logic                  is_run_ff, is_run_in;
   logic [7:0]            left_ff, left_in;
   logic [1:0]            comp_idx_ff, comp_idx_in;
   logic [7:0]            held_ff [3];
   logic [7:0]            held_in [3];
   logic [COUNT_BITS-1:0] done_ff, done_in;

   // result stages
   logic      out_valid_ff, skid_valid_ff;
   pixel_type out_ff, skid_ff;

   logic      accept;
   logic      emit;
   logic      out_free;
   pixel_type pix;

   logic [7:0]            in_byte;
   logic [1:0]            last_idx;
   logic                  over;
   logic [COUNT_BITS-1:0] remain;
   logic [7:0]            cnt_raw;
   logic                  hit;
   logic [7:0]            left_next;
   logic [COUNT_BITS:0]   done_inc;
   logic [WIDE_BITS-1:0]  total_wide;
   logic [WIDE_BITS-1:0]  mask_wide;

   assign in_byte    = req_tdata;
   assign req_tready = !skid_valid_ff;
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !out_valid_ff || rsp_tready;

   // saturated, non-zero pixel limit taken at configuration time
   always_comb begin
      total_wide = WIDE_BITS'(csr_wdata);
      mask_wide  = WIDE_BITS'({COUNT_BITS{1'b1}});
      if (total_wide == '0) begin
         limit_in = COUNT_BITS'(1);
      end else if (total_wide > mask_wide) begin
         limit_in = {COUNT_BITS{1'b1}};
      end else begin
         limit_in = total_wide[COUNT_BITS-1:0];
      end
   end

   always_comb begin
      last_idx  = (bpp_ff == BPP_RGB) ? LAST_RGB : LAST_RGBA;
      over      = done_ff >= limit_ff;
      remain    = limit_ff - done_ff;
      cnt_raw   = (is_run_ff && left_ff != 8'd0) ? left_ff : 8'd1;
      hit       = COUNT_BITS'(cnt_raw) >= remain;
      left_next = is_run_ff ? 8'd0 : ((left_ff != 8'd0) ? left_ff - 8'd1 : 8'd0);
      done_inc  = {1'b0, done_ff} + (COUNT_BITS + 1)'(1);

      expect_header_in = expect_header_ff;
      is_run_in        = is_run_ff;
      left_in          = left_ff;
      comp_idx_in      = comp_idx_ff;
      held_in          = held_ff;
      done_in          = done_ff;
      emit             = 1'b0;

      pix.blue  = held_ff[0];
      pix.green = held_ff[1];
      if (last_idx == LAST_RGB) begin
         pix.red   = in_byte;
         pix.alpha = 8'd0;
      end else begin
         pix.red   = held_ff[2];
         pix.alpha = in_byte;
      end
      pix.repeat_count = 8'd1;
      pix.image_end    = 1'b0;

      if (rle_ff && expect_header_ff) begin
         if (over) begin
            done_in = '0;
         end
         is_run_in        = in_byte[RUN_FLAG_BIT];
         left_in          = {1'b0, in_byte[6:0]} + 8'd1;
         expect_header_in = 1'b0;
         comp_idx_in      = 2'd0;
      end else if (comp_idx_ff < last_idx) begin
         case (comp_idx_ff)
            2'd0:    held_in[0] = in_byte;
            2'd1:    held_in[1] = in_byte;
            default: held_in[2] = in_byte;
         endcase
         comp_idx_in = comp_idx_ff + 2'd1;
      end else begin
         comp_idx_in = 2'd0;
         if (!rle_ff) begin
            emit = 1'b1;
            if (done_inc >= {1'b0, limit_ff}) begin
               pix.image_end = 1'b1;
               done_in       = '0;
            end else begin
               done_in = done_inc[COUNT_BITS-1:0];
            end
         end else if (over) begin
            // rest of a packet after the image ended is dropped
            if (is_run_ff || left_ff <= 8'd1) begin
               left_in          = 8'd0;
               expect_header_in = 1'b1;
               done_in          = '0;
            end else begin
               left_in = left_ff - 8'd1;
            end
         end else begin
            emit    = 1'b1;
            left_in = left_next;
            if (hit) begin
               // run clamped to the pixels that remain
               pix.repeat_count = remain[7:0];
               pix.image_end    = 1'b1;
               done_in          = (left_next == 8'd0) ? '0 : limit_ff;
            end else begin
               pix.repeat_count = cnt_raw;
               done_in          = done_ff + COUNT_BITS'(cnt_raw);
            end
            if (left_next == 8'd0) begin
               expect_header_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bpp_ff           <= BPP_RESET;
         rle_ff           <= RLE_RESET;
         limit_ff         <= COUNT_BITS'(1);
         expect_header_ff <= 1'b1;
         is_run_ff        <= 1'b0;
         left_ff          <= 8'd0;
         comp_idx_ff      <= 2'd0;
         held_ff          <= '{default: 8'd0};
         done_ff          <= '0;
         out_valid_ff     <= 1'b0;
         skid_valid_ff    <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_BYTES_PER_PIXEL: bpp_ff   <= csr_wdata[2:0];
               CSR_RLE_ENABLE:      rle_ff   <= csr_wdata[0];
               CSR_PIXEL_TOTAL:     limit_ff <= limit_in;
               default:             ;
            endcase
         end
         if (accept) begin
            expect_header_ff <= expect_header_in;
            is_run_ff        <= is_run_in;
            left_ff          <= left_in;
            comp_idx_ff      <= comp_idx_in;
            held_ff          <= held_in;
            done_ff          <= done_in;
         end
         if (out_free) begin
            if (skid_valid_ff) begin
               out_valid_ff  <= 1'b1;
               skid_valid_ff <= accept && emit;
            end else begin
               out_valid_ff <= accept && emit;
            end
         end else if (accept && emit) begin
            skid_valid_ff <= 1'b1;
         end
      end
   end

   // result payload, no reset needed
   always_ff @(posedge clock) begin
      if (out_free) begin
         if (skid_valid_ff) begin
            out_ff <= skid_ff;
            if (accept && emit) begin
               skid_ff <= pix;
            end
         end else if (accept && emit) begin
            out_ff <= pix;
         end
      end else if (accept && emit) begin
         skid_ff <= pix;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_ff.repeat_count, out_ff.alpha, out_ff.blue,
                        out_ff.green, out_ff.red};
   assign rsp_tlast  = out_ff.image_end;

   // skid stage only fills behind a held output transfer
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid stage holds a transfer while the output register is empty");

   // a pending result is never lost while the sink stalls
   a_out_held: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_tready) |=> out_valid_ff)
      else $error("pending result dropped without a transfer");

   a_repeat_nonzero: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_ff.repeat_count != 8'd0))
      else $error("result with zero repeat count");

   // a header byte always opens a packet
   a_header_opens: assert property (@(posedge clock) disable iff (reset)
      (accept && rle_ff && expect_header_ff) |=> !expect_header_ff)
      else $error("header byte did not open a packet");

endmodule

`default_nettype wire

[tb/sv/tga_rle_pixel_decoder_unit_tb.sv]
// testbench for tga_rle_pixel_decoder_unit: byte stream in, decoded pixels out
// holds its own model of the decoder in a scoreboard class and checks each pixel transfer
// depends on tgarle_pkg and the decoder rtl only
`timescale 1ns / 1ps

module tga_rle_pixel_decoder_unit_tb;
   import tgarle_pkg::*;

   localparam int unsigned CYCLE_LIMIT   = 200000;
   localparam int unsigned RANDOM_GOAL   = 550;
   localparam int unsigned QUIET_TAIL    = 120;
   localparam int unsigned HOLD_CYCLES   = 300;
   localparam int unsigned SETTLE_CYCLES = 6;
   localparam logic [31:0] TOTAL_MAX     = 32'hffff_ffff;
   localparam logic [31:0] TOTAL_WIDEST  = 32'd4294836225;   // 65535 by 65535 image

   class pixel_scoreboard;
      logic [2:0]      bpp;
      logic            rle_on;
      logic [31:0]     total;
      bit              expect_header;
      bit              packet_is_run;
      int unsigned     packet_left;
      logic [1:0]      comp_pos;
      logic [7:0]      held [3];
      longint unsigned pixels_done;
      pixel_type       expected_pixels [$];
      int              fail_count;

      function new();
         bpp = BPP_RESET;
         rle_on = RLE_RESET;
         total = 32'd1;
         expect_header = 1'b1;
         packet_is_run = 1'b0;
         packet_left = 0;
         comp_pos = '0;
         foreach (held[i]) held[i] = '0;
         pixels_done = 0;
         fail_count = 0;
      endfunction

      function void set_register(logic [CSR_INDEX_BITS-1:0] idx, logic [CSR_DATA_BITS-1:0] value);
         case (idx)
            CSR_BYTES_PER_PIXEL: bpp = value[2:0];
            CSR_RLE_ENABLE:      rle_on = value[0];
            CSR_PIXEL_TOTAL:     total = value;
            default: ;
         endcase
      endfunction

      // advance the decoder by one accepted byte, queueing the pixel it completes
      function void note_byte(logic [7:0] b);
         logic [1:0]      last_pos;
         longint unsigned limit;
         longint unsigned count;
         bit              ends;
         pixel_type       px;
         last_pos = (bpp == BPP_RGB) ? LAST_RGB : LAST_RGBA;
         limit = (total == 0) ? 1 : total;
         count = 1;
         ends = 1'b0;
         if (rle_on && expect_header) begin
            if (pixels_done >= limit) pixels_done = 0;
            packet_is_run = b[RUN_FLAG_BIT];
            packet_left = b[6:0] + 1;
            expect_header = 1'b0;
            comp_pos = '0;
            return;
         end
         if (comp_pos < last_pos) begin
            held[comp_pos] = b;
            comp_pos = comp_pos + 1'b1;
            return;
         end
         comp_pos = '0;
         px.blue = held[0];
         px.green = held[1];
         if (last_pos == LAST_RGB) begin
            px.red = b;
            px.alpha = '0;
         end else begin
            px.red = held[2];
            px.alpha = b;
         end
         if (!rle_on) begin
            if (pixels_done + 1 >= limit) begin
               ends = 1'b1;
               pixels_done = 0;
            end else begin
               pixels_done++;
            end
         end else begin
            if (pixels_done >= limit) begin
               // image already complete: rest of the packet is swallowed
               if (packet_is_run || packet_left <= 1) begin
                  packet_left = 0;
                  expect_header = 1'b1;
                  pixels_done = 0;
               end else begin
                  packet_left--;
               end
               return;
            end
            if (packet_is_run) begin
               count = (packet_left == 0) ? 1 : packet_left;
               if (count > limit - pixels_done) count = limit - pixels_done;
               packet_left = 0;
            end else if (packet_left > 0) begin
               packet_left--;
            end
            pixels_done += count;
            if (pixels_done >= limit) begin
               ends = 1'b1;
               if (packet_left == 0) pixels_done = 0;
            end
            if (packet_left == 0) expect_header = 1'b1;
         end
         px.repeat_count = count[7:0];
         px.image_end = ends;
         expected_pixels.push_back(px);
      endfunction

      function void compare_field(string name, logic [7:0] want, logic [7:0] got);
         if (want !== got) begin
            $error("%s mismatch: expected %0h, actual %0h", name, want, got);
            fail_count++;
         end
      endfunction

      function void check_pixel(logic [RSP_DATA_BITS-1:0] data, logic last);
         pixel_type want;
         if (expected_pixels.size() == 0) begin
            $error("pixel transfer with nothing expected: data %h last %b", data, last);
            fail_count++;
            return;
         end
         want = expected_pixels.pop_front();
         compare_field("red", want.red, data[7:0]);
         compare_field("green", want.green, data[15:8]);
         compare_field("blue", want.blue, data[23:16]);
         compare_field("alpha", want.alpha, data[31:24]);
         compare_field("repeat_count", want.repeat_count, data[39:32]);
         compare_field("image_end", want.image_end, last);
      endfunction
   endclass

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_tvalid = 1'b0;
   wire logic                 req_tready;
   logic [7:0]                req_tdata = '0;
   wire logic                 rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   wire logic [RSP_DATA_BITS-1:0] rsp_tdata;
   wire logic                 rsp_tlast;
   logic                      csr_we = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_wdata = '0;

   pixel_scoreboard pix_sb = new();
   int unsigned     send_idle_pct = 0;
   int unsigned     recv_idle_pct = 0;
   bit              hold_request = 1'b0;
   int unsigned     pixel_bytes = 4;
   bit              rle_mode = 1'b1;
   int unsigned     bytes_sent = 0;
   int unsigned     cycle_count = 0;

   tga_rle_pixel_decoder_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) pix_sb.check_pixel(rsp_tdata, rsp_tlast);
         if (req_tvalid && req_tready) pix_sb.note_byte(req_tdata);
      end
   end

   // result side: random stall bursts, plus one long hold-off on request
   initial begin : result_sink
      int unsigned stall_left;
      int unsigned hold_left;
      stall_left = 0;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if ($urandom_range(99) < recv_idle_pct) begin
            stall_left = $urandom_range(12);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Verification failed");
      $finish;
   end

   task automatic send_byte(input logic [7:0] value);
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= value;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      bytes_sent++;
   endtask

   task automatic send_pixel();
      repeat (pixel_bytes) send_byte(8'($urandom_range(255)));
   endtask

   // stop offering, let every expected pixel arrive, then give the pipeline time to empty
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pix_sb.expected_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      pix_sb.set_register(idx, value);
      @(posedge clock);
   endtask

   task automatic set_config(input logic [2:0] bpp, input logic rle, input logic [31:0] total);
      logic [31:0] junk;
      junk = ($urandom_range(3) == 0) ? $urandom : 32'd0;
      write_reg(CSR_BYTES_PER_PIXEL, {junk[31:3], bpp});
      write_reg(CSR_RLE_ENABLE, {junk[31:1], rle});
      write_reg(CSR_PIXEL_TOTAL, total);
      pixel_bytes = (bpp == BPP_RGB) ? 3 : 4;
      rle_mode = rle;
   endtask

   // mostly well-formed packets with random content, some stray and truncated ones
   task automatic random_stream(input int unsigned stop_at);
      int unsigned pick;
      int unsigned n;
      while (bytes_sent < stop_at) begin
         pick = $urandom_range(99);
         if (pick < 8) begin
            send_byte(8'($urandom_range(255)));
         end else if (!rle_mode) begin
            send_pixel();
         end else if (pick < 50) begin
            send_byte({1'b1, 7'($urandom_range(127))});
            send_pixel();
         end else begin
            n = ($urandom_range(9) == 0) ? $urandom_range(1, 24) : $urandom_range(1, 4);
            send_byte({1'b0, 7'(n - 1)});
            // a truncated packet lets the next header land inside pixel data
            if (pick > 95 && n > 1) n = n - 1;
            repeat (n) send_pixel();
         end
      end
   endtask

   initial begin : stimulus
      int unsigned phase;
      int unsigned stop_at;
      logic [2:0]  bpp;
      logic        rle;
      logic [31:0] total;
      phase = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: run of 128 clamped to a single-pixel image
      send_byte(8'hff);
      send_byte(8'h00);
      send_byte(8'hff);
      send_byte(8'h00);
      send_byte(8'hff);
      wait_drained();
      // zero total acts as one; second literal pixel is dropped
      set_config(BPP_RGB, 1'b1, 32'd0);
      send_byte(8'h01);
      send_byte(8'hff);
      send_byte(8'h00);
      send_byte(8'hff);
      send_byte(8'h12);
      send_byte(8'h34);
      send_byte(8'h56);
      wait_drained();
      // odd pixel size behaves as four bytes, raw mode
      set_config(3'd7, 1'b0, 32'd1);
      send_byte(8'h80);
      send_byte(8'h7f);
      send_byte(8'h01);
      send_byte(8'hfe);
      wait_drained();
      // literal packet left part-way, with a pixel half assembled
      set_config(BPP_RGB, 1'b1, 32'd10);
      send_byte(8'h02);
      send_byte(8'haa);
      send_byte(8'h55);
      send_byte(8'hcc);
      send_byte(8'h33);
      wait_drained();
      // total lowered to the count and pixel size widened mid-pixel
      set_config(3'd4, 1'b1, 32'd1);
      send_byte(8'h0f);
      send_byte(8'hf0);
      send_byte(8'h3c);
      wait_drained();
      // raw mode in the middle of a literal packet
      set_config(3'd4, 1'b0, 32'd1);
      repeat (4) send_byte(8'($urandom_range(255)));
      wait_drained();
      set_config(3'd4, 1'b1, TOTAL_MAX);
      set_config(3'd4, 1'b1, 32'd1);
      repeat (4) send_byte(8'($urandom_range(255)));
      wait_drained();

      stop_at = bytes_sent + RANDOM_GOAL;
      while (bytes_sent < stop_at) begin
         case ($urandom_range(9))
            0, 1, 2, 3: bpp = BPP_RGB;
            4, 5, 6, 7: bpp = 3'd4;
            default: bpp = 3'($urandom_range(7));
         endcase
         rle = ($urandom_range(3) != 0);
         case ($urandom_range(7))
            0: total = 32'd0;
            1: total = TOTAL_MAX;
            2: total = TOTAL_WIDEST;
            3, 4: total = $urandom_range(1, 6);
            default: total = $urandom_range(7, 200);
         endcase
         if (bytes_sent + QUIET_TAIL >= stop_at) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end else begin
            send_idle_pct = ($urandom_range(2) == 0) ? 0 : $urandom_range(5, 35);
            recv_idle_pct = ($urandom_range(2) == 0) ? 0 : $urandom_range(5, 35);
         end
         set_config(bpp, rle, total);
         if (phase == 1) begin
            rle_mode = 1'b0;
            hold_request = 1'b1;
         end
         random_stream(bytes_sent + $urandom_range(40, 90));
         if (phase == 2) begin
            wait_drained();
            random_stream(bytes_sent + $urandom_range(20, 40));
         end
         wait_drained();
         phase++;
      end

      if (pix_sb.fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

[sim.f]
rtl/tgarle_pkg.sv
rtl/tga_rle_pixel_decoder_unit.sv
tb/sv/tga_rle_pixel_decoder_unit_tb.sv
